>>> design/srh_pkg.sv
// Package for the horizontal interface refraction block.
// Holds the fixed-point sizes, pipeline depths and the item type shared by all modules.
`timescale 1ns / 1ps
package srh_pkg;

  localparam int SFB      = 40;
  localparam int VB       = 16;
  localparam int VMW      = (VB < 16) ? VB : 16;
  localparam int DW       = 2 * VMW;
  localparam int NB       = 2 * SFB;
  localparam int QW       = NB + 1;
  localparam int LW       = (QW + 1 > 65) ? QW + 1 : 65;
  localparam int DIV_PER  = 8;
  localparam int DIV_STG  = (QW + DIV_PER - 1) / DIV_PER;
  localparam int SQ_STEPS = 32;
  localparam int SQ_PER   = 4;
  localparam int SQ_STG   = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QCW      = $clog2(QDEPTH + 1);

  localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_SAT = 32'h8000_0000;

  typedef struct packed {
    logic          refl;
    logic          neg;
    logic [31:0]   refl_res;
    logic [63:0]   sq;
    logic [DW-1:0] d_enter;
    logic [DW-1:0] d_leave;
  } item_t;

endpackage

>>> design/srh_if.sv
// Stream interfaces for the input rays and the result beats.
// Depends on no other file.
`timescale 1ns / 1ps
interface srh_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] slowness_z;
  logic [15:0]        vel_above;
  logic [15:0]        vel_below;
  modport source (output valid, mode, slowness_z, vel_above, vel_below, input ready);
  modport sink (input valid, mode, slowness_z, vel_above, vel_below, output ready);
endinterface

interface srh_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_slowness_z;
  logic               evanescent;
  modport source (output valid, new_slowness_z, evanescent, input ready);
  modport sink (input valid, new_slowness_z, evanescent, output ready);
endinterface

>>> design/srh_front.sv
// Front stage: accepts rays, picks the entered layer and forms the squares.
// Depends on srh_pkg and srh_in_if.
`timescale 1ns / 1ps
module srh_front import srh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  srh_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     push,
  output item_t    push_item
);

  logic        fv_r;
  item_t       fi_r;
  item_t       item_nxt;
  logic [31:0] raw;
  logic [31:0] mag;
  logic [15:0] v_enter;
  logic [15:0] v_leave;
  logic [VMW-1:0] ve_m;
  logic [VMW-1:0] vl_m;

  assign in_ch.ready = !fv_r || !q_full;
  assign push        = fv_r && !q_full;
  assign push_item   = fi_r;

  always_comb begin
    raw     = in_ch.slowness_z;
    mag     = raw[31] ? (32'd0 - raw) : raw;
    v_enter = raw[31] ? in_ch.vel_above : in_ch.vel_below;
    v_leave = raw[31] ? in_ch.vel_below : in_ch.vel_above;
    ve_m    = (v_enter[VMW-1:0] == '0) ? VMW'(1) : v_enter[VMW-1:0];
    vl_m    = (v_leave[VMW-1:0] == '0) ? VMW'(1) : v_leave[VMW-1:0];
    item_nxt.refl     = in_ch.mode;
    item_nxt.neg      = raw[31];
    item_nxt.refl_res = (raw == NEG_SAT) ? POS_SAT : (32'd0 - raw);
    item_nxt.sq       = 64'(mag) * 64'(mag);
    item_nxt.d_enter  = DW'(ve_m) * DW'(ve_m);
    item_nxt.d_leave  = DW'(vl_m) * DW'(vl_m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ch.ready) begin
      fv_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      fi_r <= item_nxt;
    end
  end

endmodule

>>> design/srh_queue.sv
// Two-entry queue between the front stage and the arithmetic pipeline.
// Depends on srh_pkg.
`timescale 1ns / 1ps
module srh_queue import srh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QCW-1:0] cnt_r;

  assign full       = (cnt_r == QCW'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == QAW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QAW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(push) - QCW'(pop);
    end
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= QCW'(QDEPTH))
    else $error("queue count exceeds depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_r != '0)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push lost");

endmodule

>>> design/srh_back.sv
// Arithmetic pipeline: two inverse squares by restoring division, radicand, square root.
// Depends on srh_pkg and srh_out_if.
`timescale 1ns / 1ps
module srh_back import srh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  item_t    head_item,
  output logic     pop,
  srh_out_if.source out_ch
);

  typedef struct packed {
    item_t         it;
    logic [DW-1:0] rt;
    logic [DW-1:0] ri;
    logic [QW-1:0] qt;
    logic [QW-1:0] qi;
  } div_t;

  typedef struct packed {
    logic          refl;
    logic          neg;
    logic [31:0]   refl_res;
    logic [LW-1:0] lhs;
    logic [QW-1:0] ti;
  } add_t;

  typedef struct packed {
    logic        refl;
    logic        neg;
    logic        ev;
    logic        big;
    logic [31:0] refl_res;
    logic [62:0] x;
    logic [62:0] res;
  } sq_t;

  function automatic div_t div_stage(div_t a, int s);
    div_t        r;
    logic [DW:0] t;
    int          idx;
    r = a;
    for (int k = 0; k < DIV_PER; k++) begin
      idx = s * DIV_PER + k;
      if (idx < QW) begin
        t = {r.rt, (idx == 0) ? 1'b1 : 1'b0};
        if (t >= {1'b0, r.it.d_enter}) begin
          t    = t - {1'b0, r.it.d_enter};
          r.qt = {r.qt[QW-2:0], 1'b1};
        end else begin
          r.qt = {r.qt[QW-2:0], 1'b0};
        end
        r.rt = t[DW-1:0];
        t = {r.ri, (idx == 0) ? 1'b1 : 1'b0};
        if (t >= {1'b0, r.it.d_leave}) begin
          t    = t - {1'b0, r.it.d_leave};
          r.qi = {r.qi[QW-2:0], 1'b1};
        end else begin
          r.qi = {r.qi[QW-2:0], 1'b0};
        end
        r.ri = t[DW-1:0];
      end
    end
    return r;
  endfunction

  function automatic sq_t sq_stage(sq_t a, int s);
    sq_t         r;
    logic [62:0] b;
    logic [62:0] sum;
    int          idx;
    r = a;
    for (int k = 0; k < SQ_PER; k++) begin
      idx = s * SQ_PER + k;
      if (idx < SQ_STEPS) begin
        b   = 63'(1) << (62 - 2 * idx);
        sum = r.res + b;
        if (r.x >= sum) begin
          r.x   = r.x - sum;
          r.res = (r.res >> 1) + b;
        end else begin
          r.res = r.res >> 1;
        end
      end
    end
    return r;
  endfunction

  logic          en;
  div_t          div_r [DIV_STG+1];
  logic          dv_r  [DIV_STG+1];
  add_t          ad_r;
  logic          adv_r;
  sq_t           sq_r  [SQ_STG+1];
  logic          sqv_r [SQ_STG+1];
  logic          ov_r;
  logic [31:0]   ores_r;
  logic          oev_r;
  div_t          d0_nxt;
  sq_t           s0_nxt;
  logic [LW-1:0] diff;
  logic [31:0]   fin_res;
  logic          fin_ev;
  sq_t           fin;

  assign en  = !ov_r || out_ch.ready;
  assign pop = en && head_valid;

  assign out_ch.valid          = ov_r;
  assign out_ch.new_slowness_z = ores_r;
  assign out_ch.evanescent     = oev_r;

  always_comb begin
    d0_nxt.it = head_item;
    d0_nxt.rt = '0;
    d0_nxt.ri = '0;
    d0_nxt.qt = '0;
    d0_nxt.qi = '0;
    diff            = ad_r.lhs - LW'(ad_r.ti);
    s0_nxt.refl     = ad_r.refl;
    s0_nxt.neg      = ad_r.neg;
    s0_nxt.refl_res = ad_r.refl_res;
    s0_nxt.ev       = ad_r.lhs < LW'(ad_r.ti);
    s0_nxt.big      = (diff[LW-1:62] != '0);
    s0_nxt.x        = {1'b0, diff[61:0]};
    s0_nxt.res      = '0;
    fin = sq_r[SQ_STG];
    if (fin.refl) begin
      fin_res = fin.refl_res;
      fin_ev  = 1'b0;
    end else if (fin.ev) begin
      fin_res = '0;
      fin_ev  = 1'b1;
    end else if (fin.big || fin.res[62:31] != '0) begin
      fin_res = fin.neg ? NEG_SAT : POS_SAT;
      fin_ev  = 1'b0;
    end else begin
      fin_res = fin.neg ? (32'd0 - fin.res[31:0]) : fin.res[31:0];
      fin_ev  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STG; s++) begin
        dv_r[s] <= 1'b0;
      end
      for (int s = 0; s <= SQ_STG; s++) begin
        sqv_r[s] <= 1'b0;
      end
      adv_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (en) begin
      dv_r[0] <= head_valid;
      for (int s = 1; s <= DIV_STG; s++) begin
        dv_r[s] <= dv_r[s-1];
      end
      adv_r    <= dv_r[DIV_STG];
      sqv_r[0] <= adv_r;
      for (int s = 1; s <= SQ_STG; s++) begin
        sqv_r[s] <= sqv_r[s-1];
      end
      ov_r <= sqv_r[SQ_STG];
    end
    if (en) begin
      div_r[0] <= d0_nxt;
      for (int s = 1; s <= DIV_STG; s++) begin
        div_r[s] <= div_stage(div_r[s-1], s - 1);
      end
      ad_r.refl     <= div_r[DIV_STG].it.refl;
      ad_r.neg      <= div_r[DIV_STG].it.neg;
      ad_r.refl_res <= div_r[DIV_STG].it.refl_res;
      ad_r.lhs      <= LW'(div_r[DIV_STG].qt) + LW'(div_r[DIV_STG].it.sq);
      ad_r.ti       <= div_r[DIV_STG].qi;
      sq_r[0] <= s0_nxt;
      for (int s = 1; s <= SQ_STG; s++) begin
        sq_r[s] <= sq_stage(sq_r[s-1], s - 1);
      end
      ores_r <= fin_res;
      oev_r  <= fin_ev;
    end
  end

  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oev_r) |-> ores_r == '0)
    else $error("evanescent beat with nonzero slowness");

endmodule

>>> design/snell_refraction_horizontal_top.sv
// An accepted input beat passes the front register, the queue, the division stages,
// the add register, the square-root stages and the output register.
// Throughput: one beat per cycle unless stalled; division and sqrt are fully pipelined.
// Stalls on the result side hold the whole back pipeline; the queue decouples the front.
// Reset (synchronous, active low) clears valid flags, queue pointers and queue count only.
`timescale 1ns / 1ps
module snell_refraction_horizontal_top import srh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  srh_in_if.sink    in_ch,
  srh_out_if.source out_ch
);

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  srh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  srh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  srh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
